// ===== src/pfs_pkg.sv =====
// Package for the protocol field serializer: command codes, byte order
// modes and sequencer states. No dependencies.
package pfs_pkg;

   localparam int CmdWidth   = 4;
   localparam int ShiftWidth = 128;
   localparam int CountWidth = 5;

   localparam logic [CmdWidth-1:0] CMD_BYTE      = 4'd0;
   localparam logic [CmdWidth-1:0] CMD_BOOL      = 4'd1;
   localparam logic [CmdWidth-1:0] CMD_SHORT_BE  = 4'd2;
   localparam logic [CmdWidth-1:0] CMD_SHORT_LE  = 4'd3;
   localparam logic [CmdWidth-1:0] CMD_INT_BE    = 4'd4;
   localparam logic [CmdWidth-1:0] CMD_INT_LE    = 4'd5;
   localparam logic [CmdWidth-1:0] CMD_LONG_BE   = 4'd6;
   localparam logic [CmdWidth-1:0] CMD_LONG_LE   = 4'd7;
   localparam logic [CmdWidth-1:0] CMD_FLOAT_BE  = 4'd8;
   localparam logic [CmdWidth-1:0] CMD_FLOAT_LE  = 4'd9;
   localparam logic [CmdWidth-1:0] CMD_DOUBLE_BE = 4'd10;
   localparam logic [CmdWidth-1:0] CMD_DOUBLE_LE = 4'd11;
   localparam logic [CmdWidth-1:0] CMD_VARINT    = 4'd12;
   localparam logic [CmdWidth-1:0] CMD_VARLONG   = 4'd13;
   localparam logic [CmdWidth-1:0] CMD_UUID      = 4'd14;

   localparam logic [6:0] LEB_GROUP_MASK = 7'h7f;
   localparam logic [7:0] LEB_CONT_BIT   = 8'h80;

   typedef enum logic [1:0] {
      MODE_BE,
      MODE_LE,
      MODE_LEB
   } mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

endpackage

// ===== src/protocol_field_serializer.sv =====
// Protocol field serializer top level: turns one field transfer into its
// wire bytes, one byte per result transfer. Depends on pfs_pkg.
//
// Usage: a request transfer carries req_cmd, req_value and req_value_high
// (the high word of a 128-bit identifier). The block loads a 128-bit shift
// register and a byte count, then a sequencer drives one shared shift unit
// (8 bits toward the sending end for fixed-width fields, 7 bits for LEB128
// varints) to emit one byte per cycle, while the output slot is free, into
// an output register. rsp_last marks the final byte of the field.
// A request is first registered into the shift register and byte count;
// the sequencer then moves each byte into the output register. An
// unknown command is taken and yields no result.
// req_ready is low while a field is being shifted out; the output register
// lets the next request be taken while the final byte still waits.
// A stalled receiver holds rsp_out_byte and rsp_last and pauses the shift.
// Reset clears the sequencer and the output valid; no clearing pass.
module protocol_field_serializer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_cmd,
   input  logic [63:0] req_value,
   input  logic [63:0] req_value_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);

   pfs_pkg::state_type                   state_ff, state_in;
   pfs_pkg::mode_type                    mode_ff, mode_in;
   logic [pfs_pkg::ShiftWidth-1:0]       shift_ff, shift_in;
   logic [pfs_pkg::CountWidth-1:0]       count_ff, count_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]                           rsp_byte_ff, rsp_byte_in;
   logic                                 rsp_last_ff, rsp_last_in;

   logic                                 accept;
   logic                                 slot_free;
   logic [7:0]                           unit_byte;
   logic                                 unit_last;
   logic [pfs_pkg::ShiftWidth-1:0]       unit_shift;
   logic                                 leb_more;

   assign req_ready    = (state_ff == pfs_pkg::ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   assign leb_more = |shift_ff[63:7];

   // Shared shift unit: pick the next byte and advance the register.
   always_comb begin
      case (mode_ff)
         pfs_pkg::MODE_BE: begin
            unit_byte  = shift_ff[127:120];
            unit_shift = {shift_ff[119:0], 8'd0};
            unit_last  = (count_ff == 5'd1);
         end
         pfs_pkg::MODE_LE: begin
            unit_byte  = shift_ff[7:0];
            unit_shift = {8'd0, shift_ff[127:8]};
            unit_last  = (count_ff == 5'd1);
         end
         pfs_pkg::MODE_LEB: begin
            unit_byte  = {1'b0, shift_ff[6:0] & pfs_pkg::LEB_GROUP_MASK}
                         | (leb_more ? pfs_pkg::LEB_CONT_BIT : 8'd0);
            unit_shift = {7'd0, shift_ff[127:7]};
            unit_last  = !leb_more;
         end
         default: begin
            unit_byte  = 8'd0;
            unit_shift = shift_ff;
            unit_last  = 1'b1;
         end
      endcase
   end

   // Sequencer: load on a request transfer, then emit one byte per free slot.
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      shift_in     = shift_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         pfs_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = pfs_pkg::ST_BUSY;
               case (req_cmd)
                  pfs_pkg::CMD_BYTE: begin
                     mode_in  = pfs_pkg::MODE_LE;
                     shift_in = {64'd0, req_value};
                     count_in = 5'd1;
                  end
                  pfs_pkg::CMD_BOOL: begin
                     mode_in  = pfs_pkg::MODE_LE;
                     shift_in = {127'd0, |req_value};
                     count_in = 5'd1;
                  end
                  pfs_pkg::CMD_SHORT_BE: begin
                     mode_in  = pfs_pkg::MODE_BE;
                     shift_in = {req_value[15:0], 112'd0};
                     count_in = 5'd2;
                  end
                  pfs_pkg::CMD_SHORT_LE: begin
                     mode_in  = pfs_pkg::MODE_LE;
                     shift_in = {64'd0, req_value};
                     count_in = 5'd2;
                  end
                  pfs_pkg::CMD_INT_BE, pfs_pkg::CMD_FLOAT_BE: begin
                     mode_in  = pfs_pkg::MODE_BE;
                     shift_in = {req_value[31:0], 96'd0};
                     count_in = 5'd4;
                  end
                  pfs_pkg::CMD_INT_LE, pfs_pkg::CMD_FLOAT_LE: begin
                     mode_in  = pfs_pkg::MODE_LE;
                     shift_in = {64'd0, req_value};
                     count_in = 5'd4;
                  end
                  pfs_pkg::CMD_LONG_BE, pfs_pkg::CMD_DOUBLE_BE: begin
                     mode_in  = pfs_pkg::MODE_BE;
                     shift_in = {req_value, 64'd0};
                     count_in = 5'd8;
                  end
                  pfs_pkg::CMD_LONG_LE, pfs_pkg::CMD_DOUBLE_LE: begin
                     mode_in  = pfs_pkg::MODE_LE;
                     shift_in = {64'd0, req_value};
                     count_in = 5'd8;
                  end
                  pfs_pkg::CMD_VARINT: begin
                     mode_in  = pfs_pkg::MODE_LEB;
                     shift_in = {96'd0, req_value[31:0]};
                     count_in = 5'd0;
                  end
                  pfs_pkg::CMD_VARLONG: begin
                     mode_in  = pfs_pkg::MODE_LEB;
                     shift_in = {64'd0, req_value};
                     count_in = 5'd0;
                  end
                  pfs_pkg::CMD_UUID: begin
                     mode_in  = pfs_pkg::MODE_BE;
                     shift_in = {req_value_high, req_value};
                     count_in = 5'd16;
                  end
                  default: begin
                     // drop unknown command
                     state_in = pfs_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         pfs_pkg::ST_BUSY: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = unit_byte;
               rsp_last_in  = unit_last;
               shift_in     = unit_shift;
               count_in     = count_ff - 5'd1;
               if (unit_last) begin
                  state_in = pfs_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = pfs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      shift_ff    <= shift_in;
      count_ff    <= count_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ===== bench/protocol_field_serializer_tb.sv =====
`timescale 1ns / 100ps
// Testbench for protocol_field_serializer: directed and random field transfers,
// each checked byte by byte against typed expected bytes or an in-bench prediction.
// Depends on pfs_pkg and the protocol_field_serializer RTL.
module protocol_field_serializer_tb;

   localparam logic [pfs_pkg::CmdWidth-1:0] CmdUnknown = 4'd15;
   localparam int ByPredictor   = -1;
   localparam int RandomFields  = 300;
   localparam int HoldOffCycles = 80;
   localparam int HoldOffAfter  = 600;
   localparam int StallLimit    = 2000;
   localparam int TailCycles    = 20;

   typedef struct {
      logic [pfs_pkg::CmdWidth-1:0] cmd;
      logic [63:0]                  value;
      logic [63:0]                  value_high;
      int                           n_typed;
      logic [127:0]                 typed;
   } field_row_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } wire_byte_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [3:0]  req_cmd;
   logic [63:0] req_value;
   logic [63:0] req_value_high;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;

   wire_byte_type pending_bytes[$];
   int            errors;
   int            fields_sent;
   int            bytes_checked;
   logic [15:0]   cmds_seen;
   bit            steady;

   field_row_type directed_rows [25] = '{
      '{pfs_pkg::CMD_BYTE,      64'h0, 64'h0, 1, 128'h00},
      '{pfs_pkg::CMD_BYTE,      '1, '1, 1, 128'hff},
      '{pfs_pkg::CMD_BOOL,      64'h0, '1, 1, 128'h00},
      '{pfs_pkg::CMD_BOOL,      64'h8000_0000_0000_0000, 64'h0, 1, 128'h01},
      '{pfs_pkg::CMD_BOOL,      64'h1, 64'h0, 1, 128'h01},
      '{pfs_pkg::CMD_SHORT_BE,  64'hffff_ffff_ffff_1234, 64'h0, 2, 128'h1234},
      '{pfs_pkg::CMD_SHORT_LE,  64'h1234, 64'h0, 2, 128'h3412},
      '{pfs_pkg::CMD_INT_BE,    64'h0123_4567_89ab_cdef, 64'h0, ByPredictor, 128'h0},
      '{pfs_pkg::CMD_INT_LE,    '1, 64'h0, 4, 128'hffff_ffff},
      '{pfs_pkg::CMD_LONG_BE,   '1, 64'h0, 8, 128'hffff_ffff_ffff_ffff},
      '{pfs_pkg::CMD_LONG_LE,   64'h0123_4567_89ab_cdef, 64'h0, ByPredictor, 128'h0},
      '{pfs_pkg::CMD_FLOAT_BE,  64'hdead_beef_3f80_0000, 64'h0, ByPredictor, 128'h0},
      '{pfs_pkg::CMD_FLOAT_LE,  64'hdead_beef_3f80_0000, 64'h0, ByPredictor, 128'h0},
      '{pfs_pkg::CMD_DOUBLE_BE, 64'hc000_0000_0000_0001, 64'h0, ByPredictor, 128'h0},
      '{pfs_pkg::CMD_DOUBLE_LE, 64'h0, '1, 8, 128'h0},
      '{pfs_pkg::CMD_VARINT,    64'h0, 64'h0, 1, 128'h00},
      '{pfs_pkg::CMD_VARINT,    64'h7f, 64'h0, 1, 128'h7f},
      '{pfs_pkg::CMD_VARINT,    64'hdead_beef_0000_0080, 64'h0, 2, 128'h8001},
      '{pfs_pkg::CMD_VARINT,    64'h0000_0000_ffff_ffff, 64'h0, 5, 128'hff_ffff_ff0f},
      '{pfs_pkg::CMD_VARLONG,   '1, 64'h0, 10,
        128'hffff_ffff_ffff_ffff_ff01},
      '{pfs_pkg::CMD_VARLONG,   64'h8000_0000_0000_0000, 64'h0, 10,
        128'h8080_8080_8080_8080_8001},
      '{pfs_pkg::CMD_VARLONG,   64'd300, 64'h0, ByPredictor, 128'h0},
      '{pfs_pkg::CMD_UUID,      '1, '1, 16, '1},
      '{pfs_pkg::CMD_UUID,      64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff,
        ByPredictor, 128'h0},
      '{CmdUnknown,             '1, '1, 0, 128'h0}
   };

   protocol_field_serializer DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_value     (req_value),
      .req_value_high(req_value_high),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic void predict_wire_bytes(
      input logic [pfs_pkg::CmdWidth-1:0] cmd,
      input logic [63:0]                  value,
      input logic [63:0]                  value_high);
      logic [127:0] word;
      logic [63:0]  group_src;
      logic [7:0]   field_bytes[$];
      int           nbytes;
      bit           big_endian;
      int           idx;
      word       = {64'h0, value};
      nbytes     = 0;
      big_endian = 1'b1;
      case (cmd)
         pfs_pkg::CMD_BYTE: nbytes = 1;
         pfs_pkg::CMD_BOOL: word = {127'h0, |value};
         pfs_pkg::CMD_SHORT_BE: nbytes = 2;
         pfs_pkg::CMD_SHORT_LE: begin
            nbytes = 2;
            big_endian = 1'b0;
         end
         pfs_pkg::CMD_INT_BE, pfs_pkg::CMD_FLOAT_BE: nbytes = 4;
         pfs_pkg::CMD_INT_LE, pfs_pkg::CMD_FLOAT_LE: begin
            nbytes = 4;
            big_endian = 1'b0;
         end
         pfs_pkg::CMD_LONG_BE, pfs_pkg::CMD_DOUBLE_BE: nbytes = 8;
         pfs_pkg::CMD_LONG_LE, pfs_pkg::CMD_DOUBLE_LE: begin
            nbytes = 8;
            big_endian = 1'b0;
         end
         pfs_pkg::CMD_UUID: begin
            word = {value_high, value};
            nbytes = 16;
         end
         default: ;
      endcase
      if (cmd == pfs_pkg::CMD_BOOL) nbytes = 1;
      for (int i = 0; i < nbytes; i++) begin
         idx = big_endian ? nbytes - 1 - i : i;
         field_bytes.push_back(word[8*idx +: 8]);
      end
      if (cmd == pfs_pkg::CMD_VARINT || cmd == pfs_pkg::CMD_VARLONG) begin
         group_src = (cmd == pfs_pkg::CMD_VARINT) ? {32'h0, value[31:0]} : value;
         while ((group_src & ~64'h7f) != 0) begin
            field_bytes.push_back(pfs_pkg::LEB_CONT_BIT | {1'b0, group_src[6:0]});
            group_src = group_src >> 7;
         end
         field_bytes.push_back({1'b0, group_src[6:0]});
      end
      foreach (field_bytes[i])
         pending_bytes.push_back('{field_bytes[i], i == field_bytes.size() - 1});
   endfunction

   task automatic send_field(input logic [pfs_pkg::CmdWidth-1:0] cmd,
                             input logic [63:0] value,
                             input logic [63:0] value_high, input int n_typed,
                             input logic [127:0] typed);
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_value      <= value;
      req_value_high <= value_high;
      do @(posedge clock); while (!req_ready);
      if (n_typed == ByPredictor)
         predict_wire_bytes(cmd, value, value_high);
      else
         for (int i = 0; i < n_typed; i++)
            pending_bytes.push_back('{typed[8*(n_typed-1-i) +: 8], i == n_typed - 1});
      fields_sent++;
      cmds_seen[cmd] = 1'b1;
      if (!steady && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_bytes.size() != 0);
   endtask

   function automatic logic [63:0] random_field_value();
      case ($urandom_range(0, 4))
         0, 1: return {$urandom, $urandom};
         2: return 64'($urandom_range(0, 1000));
         3: return (64'd1 << (7 * $urandom_range(1, 9))) - 64'($urandom_range(0, 1));
         default: return {($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0, $urandom};
      endcase
   endfunction

   function automatic logic [pfs_pkg::CmdWidth-1:0] random_cmd();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 16) return pick[pfs_pkg::CmdWidth-1:0];
      return pick[0] ? pfs_pkg::CMD_VARLONG : pfs_pkg::CMD_VARINT;
   endfunction

   always @(posedge clock) begin
      wire_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         bytes_checked++;
         if (pending_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected byte: expected none, actual byte %02h last %0b",
                     $time, rsp_out_byte, rsp_last);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.data) begin
               errors++;
               $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                        $time, want.data, rsp_out_byte);
            end
            if (rsp_last !== want.last) begin
               errors++;
               $display("%0t: last mismatch: expected %0b, actual %0b",
                        $time, want.last, rsp_last);
            end
         end
      end
   end

   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && bytes_checked >= HoldOffAfter) begin
            held      = 1'b1;
            hold_left = HoldOffCycles;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= 9);
         end
      end
   end

   initial begin
      int stuck;
      stuck = 0;
      while (stuck < StallLimit) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stuck = 0;
         else
            stuck++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = '0;
      req_value      = '0;
      req_value_high = '0;
      errors         = 0;
      fields_sent    = 0;
      bytes_checked  = 0;
      cmds_seen      = '0;
      steady         = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_field(directed_rows[i].cmd, directed_rows[i].value,
                    directed_rows[i].value_high, directed_rows[i].n_typed,
                    directed_rows[i].typed);
      wait_drained();

      for (int i = 0; i < RandomFields; i++) begin
         steady = (i >= 100 && i < 160);
         if (i == 230) wait_drained();
         send_field(random_cmd(), random_field_value(), {$urandom, $urandom},
                    ByPredictor, '0);
      end
      steady = 1'b0;
      wait_drained();
      repeat (TailCycles) @(posedge clock);

      $display("Run covered %0d fields over %0d command codes, %0d bytes checked,",
               fields_sent, $countones(cmds_seen), bytes_checked);
      $display("with a %0d-cycle receiver hold-off and a full drain mid-run.",
               HoldOffCycles);
      if (errors == 0 && pending_bytes.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
